@@ hw/rtl/dsf3_pkg.sv @@
// Package for the damped spring force block: fixed-point constants, channel
// payload types, pipeline stage types and shared arithmetic functions.
// No dependencies.
package dsf3_pkg;

    localparam int FRAC = 16;
    localparam int QW = FRAC + 1;
    localparam int DOTW = FRAC + 3;
    localparam int SQ_STEPS = 32;

    typedef enum logic [1:0] {
        CFG_SPRING,
        CFG_DAMPING,
        CFG_REST,
        CFG_ENABLED
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] rel_pos_x;
        logic signed [31:0] rel_pos_y;
        logic signed [31:0] rel_pos_z;
        logic signed [31:0] rel_vel_x;
        logic signed [31:0] rel_vel_y;
        logic signed [31:0] rel_vel_z;
        logic               a_free;
        logic               b_free;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               applied;
        logic [31:0]        current_length;
    } out_item_t;

    typedef struct packed {
        cfg_reg_t    index;
        logic [31:0] value;
    } cfg_req_t;

    typedef struct packed {
        logic [2:0][31:0] pmag;
        logic [2:0]       psgn;
        logic [2:0][31:0] vmag;
        logic [2:0]       vsgn;
        logic             on;
    } side_t;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] r;
    } isq_t;

    typedef struct packed {
        logic [32:0]   rem;
        logic [QW-1:0] q;
    } div_t;

    typedef struct packed {
        logic        on;
        logic [31:0] len_p;
        logic [31:0] len_v;
        logic [2:0]  psgn;
        logic [2:0]  vsgn;
    } dcar_t;

    typedef struct packed {
        logic                on;
        logic [31:0]         len;
        logic [2:0][QW-1:0]  umag;
        logic [2:0]          usgn;
        logic [2:0][QW-1:0]  wmag;
        logic [2:0]          wsgn;
    } carry_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic signed [31:0] qfin(input logic neg, input logic [63:0] prod);
        logic [63:0] p;
        p = prod >> FRAC;
        if (neg)
        begin
            if (p > 64'h0000_0000_8000_0000)
            begin
                return 32'h8000_0000;
            end
            return 32'(~p + 64'd1);
        end
        if (p > 64'h0000_0000_7FFF_FFFF)
        begin
            return 32'h7FFF_FFFF;
        end
        return p[31:0];
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31])
        begin
            return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic isq_t isq_step(input isq_t x, input int s);
        logic [63:0] bitv;
        logic [63:0] t;
        isq_t        y;
        bitv = 64'd1 << (62 - 2 * s);
        t = x.r + bitv;
        if (x.n >= t)
        begin
            y.n = x.n - t;
            y.r = (x.r >> 1) + bitv;
        end
        else
        begin
            y.n = x.n;
            y.r = x.r >> 1;
        end
        return y;
    endfunction

    function automatic div_t div_step(input div_t x, input logic din, input logic [31:0] d);
        logic [33:0] t;
        div_t        y;
        t = {x.rem, din};
        if (t >= {2'b00, d})
        begin
            t = t - {2'b00, d};
            y.q = {x.q[QW-2:0], 1'b1};
        end
        else
        begin
            y.q = {x.q[QW-2:0], 1'b0};
        end
        y.rem = t[32:0];
        return y;
    endfunction

endpackage

@@ hw/rtl/dsf3_channels.sv @@
// Valid/ready channel interfaces for the damped spring force block:
// input items, result items and configuration writes.
// Depends on dsf3_pkg for the payload types.
interface dsf3_in_if;
    import dsf3_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dsf3_out_if;
    import dsf3_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dsf3_cfg_if;
    import dsf3_pkg::*;
    logic     valid;
    logic     ready;
    cfg_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/damped_spring_force_3d.sv @@
// Top level of the damped spring force block: a fully pipelined datapath
// from relative position and velocity to saturated Q16.16 force.
// Depends on dsf3_pkg and the channel interfaces in dsf3_channels.sv.
//
// Usage: each request on the item channel carries the position and velocity
// differences of one spring plus the two free flags. One result request per
// item leaves on the result channel, in order. The cfg channel writes the
// stiffness, damping, rest length and enable registers; it is always ready
// and should only be used while no item is in flight.
// Throughput is one item per cycle while the receiver takes results; the
// depth is set by the 32 square root stages and the 17 quotient stages of
// the six normalizing dividers, which run in parallel.
// Reset clears all valid bits and loads stiffness 0, damping 0, rest length 0
// and enabled 1. When the receiver stalls, the whole pipeline holds and the
// item channel drops ready; nothing is lost or repeated, and empty stages do
// not block acceptance while the output register is free or being taken.
module damped_spring_force_3d (
    input logic        clk,
    input logic        rst_n,
    dsf3_in_if.sink    item,
    dsf3_out_if.source result,
    dsf3_cfg_if.sink   cfg
);
    import dsf3_pkg::*;

    logic signed [31:0] spring_constant_reg;
    logic signed [31:0] damping_reg;
    logic [30:0]        rest_length_reg;
    logic               enabled_reg;

    logic adv;

    logic                 a_valid_reg;
    logic [5:0][63:0]     a_sq_reg;
    logic [5:0][63:0]     a_sq_next;
    side_t                a_side_reg;
    side_t                a_side_next;

    logic [SQ_STEPS:0]    sq_valid_reg;
    isq_t                 sq_p_reg [SQ_STEPS+1];
    isq_t                 sq_v_reg [SQ_STEPS+1];
    side_t                sq_side_reg [SQ_STEPS+1];
    isq_t                 sq_p0_next;
    isq_t                 sq_v0_next;

    logic [QW-1:0]        dv_valid_reg;
    div_t                 dv_reg [QW][6];
    dcar_t                dcar_reg [QW];
    div_t                 dv0_next [6];
    dcar_t                dcar0_next;

    logic                 c1_valid_reg;
    logic [63:0]          c1_sprod_reg;
    logic                 c1_sneg_reg;
    logic [2:0][2*QW-1:0] c1_tprod_reg;
    logic [2:0]           c1_tneg_reg;
    carry_t               c1_car_reg;
    logic [63:0]          c1_sprod_next;
    logic                 c1_sneg_next;
    logic [2:0][2*QW-1:0] c1_tprod_next;
    logic [2:0]           c1_tneg_next;
    carry_t               c1_car_next;

    logic                    c2_valid_reg;
    logic signed [31:0]      c2_s_reg;
    logic signed [DOTW-1:0]  c2_dot_reg;
    carry_t                  c2_car_reg;
    logic signed [DOTW-1:0]  c2_dot_next;

    logic                 c3_valid_reg;
    logic [63:0]          c3_dprod_reg;
    logic                 c3_dneg_reg;
    logic signed [31:0]   c3_s_reg;
    carry_t               c3_car_reg;
    logic [63:0]          c3_dprod_next;
    logic                 c3_dneg_next;

    logic                 c4_valid_reg;
    logic signed [31:0]   c4_d_reg;
    logic signed [31:0]   c4_s_reg;
    carry_t               c4_car_reg;

    logic                   c5_valid_reg;
    logic [2:0][31+QW:0]    c5_fs_reg;
    logic [2:0][31+QW:0]    c5_fd_reg;
    logic [2:0]             c5_fsneg_reg;
    logic [2:0]             c5_fdneg_reg;
    logic                   c5_on_reg;
    logic [31:0]            c5_len_reg;
    logic [2:0][31+QW:0]    c5_fs_next;
    logic [2:0][31+QW:0]    c5_fd_next;
    logic [2:0]             c5_fsneg_next;
    logic [2:0]             c5_fdneg_next;

    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t out_data_next;

    assign cfg.ready = 1'b1;
    assign adv = !out_valid_reg || result.ready;
    assign item.ready = adv;
    assign result.valid = out_valid_reg;
    assign result.data = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spring_constant_reg <= '0;
            damping_reg <= '0;
            rest_length_reg <= '0;
            enabled_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                CFG_SPRING:  spring_constant_reg <= cfg.data.value;
                CFG_DAMPING: damping_reg <= cfg.data.value;
                CFG_REST:    rest_length_reg <= cfg.data.value[30:0];
                CFG_ENABLED: enabled_reg <= cfg.data.value[0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            sq_valid_reg <= '0;
            dv_valid_reg <= '0;
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
            c3_valid_reg <= 1'b0;
            c4_valid_reg <= 1'b0;
            c5_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= item.valid;
            sq_valid_reg <= {sq_valid_reg[SQ_STEPS-1:0], a_valid_reg};
            dv_valid_reg <= {dv_valid_reg[QW-2:0], sq_valid_reg[SQ_STEPS]};
            c1_valid_reg <= dv_valid_reg[QW-1];
            c2_valid_reg <= c1_valid_reg;
            c3_valid_reg <= c2_valid_reg;
            c4_valid_reg <= c3_valid_reg;
            c5_valid_reg <= c4_valid_reg;
            out_valid_reg <= c5_valid_reg;
        end
    end

    always_comb
    begin
        a_side_next.pmag[0] = mag32(item.data.rel_pos_x);
        a_side_next.pmag[1] = mag32(item.data.rel_pos_y);
        a_side_next.pmag[2] = mag32(item.data.rel_pos_z);
        a_side_next.psgn = {item.data.rel_pos_z[31], item.data.rel_pos_y[31],
                            item.data.rel_pos_x[31]};
        a_side_next.vmag[0] = mag32(item.data.rel_vel_x);
        a_side_next.vmag[1] = mag32(item.data.rel_vel_y);
        a_side_next.vmag[2] = mag32(item.data.rel_vel_z);
        a_side_next.vsgn = {item.data.rel_vel_z[31], item.data.rel_vel_y[31],
                            item.data.rel_vel_x[31]};
        a_side_next.on = enabled_reg && (item.data.a_free || item.data.b_free);
        for (int i = 0; i < 3; i++)
        begin
            a_sq_next[i] = 64'(a_side_next.pmag[i]) * 64'(a_side_next.pmag[i]);
            a_sq_next[i+3] = 64'(a_side_next.vmag[i]) * 64'(a_side_next.vmag[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sq_reg <= a_sq_next;
            a_side_reg <= a_side_next;
        end
    end

    always_comb
    begin
        sq_p0_next.n = a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];
        sq_p0_next.r = '0;
        sq_v0_next.n = a_sq_reg[3] + a_sq_reg[4] + a_sq_reg[5];
        sq_v0_next.r = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_p_reg[0] <= sq_p0_next;
            sq_v_reg[0] <= sq_v0_next;
            sq_side_reg[0] <= a_side_reg;
        end
    end

    for (genvar s = 0; s < SQ_STEPS; s++)
    begin : g_sqrt
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_p_reg[s+1] <= isq_step(sq_p_reg[s], s);
                sq_v_reg[s+1] <= isq_step(sq_v_reg[s], s);
                sq_side_reg[s+1] <= sq_side_reg[s];
            end
        end
    end

    always_comb
    begin
        div_t init;
        side_t sd;
        sd = sq_side_reg[SQ_STEPS];
        dcar0_next.on = sd.on;
        dcar0_next.len_p = sq_p_reg[SQ_STEPS].r[31:0];
        dcar0_next.len_v = sq_v_reg[SQ_STEPS].r[31:0];
        dcar0_next.psgn = sd.psgn;
        dcar0_next.vsgn = sd.vsgn;
        for (int i = 0; i < 3; i++)
        begin
            init.rem = {2'b00, sd.pmag[i][31:1]};
            init.q = '0;
            dv0_next[i] = div_step(init, sd.pmag[i][0], dcar0_next.len_p);
            init.rem = {2'b00, sd.vmag[i][31:1]};
            dv0_next[i+3] = div_step(init, sd.vmag[i][0], dcar0_next.len_v);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0] <= dv0_next;
            dcar_reg[0] <= dcar0_next;
        end
    end

    for (genvar k = 1; k < QW; k++)
    begin : g_div
        for (genvar i = 0; i < 6; i++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_reg[k][i] <= div_step(dv_reg[k-1][i], 1'b0,
                        (i < 3) ? dcar_reg[k-1].len_p : dcar_reg[k-1].len_v);
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dcar_reg[k] <= dcar_reg[k-1];
            end
        end
    end

    always_comb
    begin
        dcar_t              dc;
        logic signed [33:0] diff;
        logic [31:0]        dmag;
        logic               kneg;
        dc = dcar_reg[QW-1];
        c1_car_next.on = dc.on;
        c1_car_next.len = dc.len_p;
        c1_car_next.usgn = dc.psgn;
        c1_car_next.wsgn = dc.vsgn;
        for (int i = 0; i < 3; i++)
        begin
            c1_car_next.umag[i] = (dc.len_p == '0) ? '0 : dv_reg[QW-1][i].q;
            c1_car_next.wmag[i] = (dc.len_v == '0) ? '0 : dv_reg[QW-1][i+3].q;
            c1_tprod_next[i] = (2*QW)'(c1_car_next.umag[i]) * (2*QW)'(c1_car_next.wmag[i]);
            c1_tneg_next[i] = dc.psgn[i] ^ dc.vsgn[i];
        end
        diff = $signed({2'b00, dc.len_p}) - $signed({3'b000, rest_length_reg});
        dmag = diff[33] ? 32'(~diff + 34'sd1) : diff[31:0];
        kneg = !spring_constant_reg[31] && (spring_constant_reg != '0);
        c1_sneg_next = kneg != diff[33];
        c1_sprod_next = 64'(mag32(spring_constant_reg)) * 64'(dmag);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_sprod_reg <= c1_sprod_next;
            c1_sneg_reg <= c1_sneg_next;
            c1_tprod_reg <= c1_tprod_next;
            c1_tneg_reg <= c1_tneg_next;
            c1_car_reg <= c1_car_next;
        end
    end

    always_comb
    begin
        logic signed [31:0] t0;
        logic signed [31:0] t1;
        logic signed [31:0] t2;
        t0 = qfin(c1_tneg_reg[0], 64'(c1_tprod_reg[0]));
        t1 = qfin(c1_tneg_reg[1], 64'(c1_tprod_reg[1]));
        t2 = qfin(c1_tneg_reg[2], 64'(c1_tprod_reg[2]));
        c2_dot_next = DOTW'(t0) + DOTW'(t1) + DOTW'(t2);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c2_s_reg <= qfin(c1_sneg_reg, c1_sprod_reg);
            c2_dot_reg <= c2_dot_next;
            c2_car_reg <= c1_car_reg;
        end
    end

    always_comb
    begin
        logic [DOTW-1:0] dotmag;
        logic            cneg;
        dotmag = c2_dot_reg[DOTW-1] ? DOTW'(~c2_dot_reg + 1'b1) : c2_dot_reg;
        cneg = !damping_reg[31] && (damping_reg != '0);
        c3_dneg_next = cneg != c2_dot_reg[DOTW-1];
        c3_dprod_next = 64'(mag32(damping_reg)) * 64'(dotmag);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c3_dprod_reg <= c3_dprod_next;
            c3_dneg_reg <= c3_dneg_next;
            c3_s_reg <= c2_s_reg;
            c3_car_reg <= c2_car_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c4_d_reg <= qfin(c3_dneg_reg, c3_dprod_reg);
            c4_s_reg <= c3_s_reg;
            c4_car_reg <= c3_car_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c5_fs_next[i] = (32+QW)'(mag32(c4_s_reg)) * (32+QW)'(c4_car_reg.umag[i]);
            c5_fd_next[i] = (32+QW)'(mag32(c4_d_reg)) * (32+QW)'(c4_car_reg.wmag[i]);
            c5_fsneg_next[i] = c4_s_reg[31] ^ c4_car_reg.usgn[i];
            c5_fdneg_next[i] = c4_d_reg[31] ^ c4_car_reg.wsgn[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c5_fs_reg <= c5_fs_next;
            c5_fd_reg <= c5_fd_next;
            c5_fsneg_reg <= c5_fsneg_next;
            c5_fdneg_reg <= c5_fdneg_next;
            c5_on_reg <= c4_car_reg.on;
            c5_len_reg <= c4_car_reg.len;
        end
    end

    always_comb
    begin
        logic signed [31:0] ts;
        logic signed [31:0] td;
        logic signed [2:0][31:0] f;
        for (int i = 0; i < 3; i++)
        begin
            ts = qfin(c5_fsneg_reg[i], 64'(c5_fs_reg[i]));
            td = qfin(c5_fdneg_reg[i], 64'(c5_fd_reg[i]));
            f[i] = c5_on_reg ? sat33({ts[31], ts} + {td[31], td}) : 32'sd0;
        end
        out_data_next.force_x = f[0];
        out_data_next.force_y = f[1];
        out_data_next.force_z = f[2];
        out_data_next.applied = c5_on_reg;
        out_data_next.current_length = c5_len_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTH
    // The square root remainder must stay within 2r for a floored root.
    a_sqrt_p : assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid_reg[SQ_STEPS] |-> (sq_p_reg[SQ_STEPS].n <= (sq_p_reg[SQ_STEPS].r << 1)))
        else $error("position square root remainder out of range");
    a_sqrt_v : assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid_reg[SQ_STEPS] |-> (sq_v_reg[SQ_STEPS].n <= (sq_v_reg[SQ_STEPS].r << 1)))
        else $error("velocity square root remainder out of range");
    // A component never exceeds the length, so the divider remainder stays below it.
    a_div_rem : assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[QW-1] && (dcar_reg[QW-1].len_p != '0)
        |-> (dv_reg[QW-1][0].rem < {1'b0, dcar_reg[QW-1].len_p}))
        else $error("divider remainder not below divisor");
    a_unit_bound : assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[QW-1] && (dcar_reg[QW-1].len_v != '0)
        |-> (dv_reg[QW-1][3].q <= (QW'(1) << FRAC)))
        else $error("unit vector component exceeds one");
`endif

endmodule

@@ bench/damped_spring_force_3d_test.sv @@
// Testbench for the damped spring force block: drives position and velocity
// differences, predicts each force result and checks it field by field.
// Depends on dsf3_pkg, the channel interfaces and the RTL top level.
`timescale 1ns / 100ps

module damped_spring_force_3d_test;
    import dsf3_pkg::*;

    localparam int FB = 16;
    localparam int LATENCY = 57;
    localparam longint LIMIT = 400000;

    logic clk;
    logic rst_n;

    dsf3_in_if  item ();
    dsf3_out_if result ();
    dsf3_cfg_if cfg ();

    damped_spring_force_3d dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // Predictor copy of the registers.
    longint k_reg;
    longint c_reg;
    longint rest_reg;
    bit     en_reg;

    in_item_t  pending_items[$];
    out_item_t expected_forces[$];
    cfg_req_t  pending_writes[$];
    int        errors;
    longint    cycle;
    int        burst_left;
    int        gap_left;
    int        stall_phase;
    int        stall_len;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint fixmul(input longint a, input longint b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] p;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = (ma * mb) >> FB;
        if ((a < 0) != (b < 0))
        begin
            return p > 64'd2147483648 ? -64'sd2147483648 : -longint'(p);
        end
        return p > 64'd2147483647 ? 64'sd2147483647 : longint'(p);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] unit_vec(input longint v[3], output longint u[3]);
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] m;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            m = v[i] < 0 ? -v[i] : v[i];
            sum = sum + m * m;
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            m = v[i] < 0 ? -v[i] : v[i];
            if (len == 0)
            begin
                u[i] = 0;
            end
            else
            begin
                u[i] = longint'((m << FB) / len);
                if (v[i] < 0)
                begin
                    u[i] = -u[i];
                end
            end
        end
        return len;
    endfunction

    function automatic out_item_t spring_force(input in_item_t x);
        longint    dp[3];
        longint    dv[3];
        longint    u[3];
        longint    w[3];
        longint    s;
        longint    dot;
        longint    d;
        logic [63:0] len;
        bit        on;
        out_item_t r;
        dp = '{longint'(x.rel_pos_x), longint'(x.rel_pos_y), longint'(x.rel_pos_z)};
        dv = '{longint'(x.rel_vel_x), longint'(x.rel_vel_y), longint'(x.rel_vel_z)};
        len = unit_vec(dp, u);
        on = en_reg && (x.a_free || x.b_free);
        r = '0;
        r.applied = on;
        r.current_length = len[31:0];
        if (on)
        begin
            s = fixmul(-k_reg, longint'(len) - rest_reg);
            void'(unit_vec(dv, w));
            dot = 0;
            for (int i = 0; i < 3; i++)
            begin
                dot += fixmul(w[i], u[i]);
            end
            d = fixmul(-c_reg, dot);
            r.force_x = 32'(sat32(fixmul(s, u[0]) + fixmul(d, w[0])));
            r.force_y = 32'(sat32(fixmul(s, u[1]) + fixmul(d, w[1])));
            r.force_z = 32'(sat32(fixmul(s, u[2]) + fixmul(d, w[2])));
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_word(input int style);
        case (style)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 255) - 128;
        endcase
    endfunction

    function automatic in_item_t rand_item();
        in_item_t x;
        int       st;
        st = $urandom_range(0, 9);
        st = st < 3 ? 0 : (st < 8 ? 1 : (st < 9 ? 2 : 3));
        x.rel_pos_x = rand_word(st);
        x.rel_pos_y = rand_word($urandom_range(0, 3) == 0 ? 0 : st);
        x.rel_pos_z = rand_word(st);
        x.rel_vel_x = rand_word($urandom_range(0, 3));
        x.rel_vel_y = rand_word($urandom_range(0, 3));
        x.rel_vel_z = rand_word($urandom_range(0, 3));
        if ($urandom_range(0, 15) == 0)
        begin
            x.rel_vel_x = 0;
            x.rel_vel_y = 0;
            x.rel_vel_z = 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            x.rel_pos_x = 0;
            x.rel_pos_y = 0;
            x.rel_pos_z = 0;
        end
        x.a_free = $urandom_range(0, 3) != 0;
        x.b_free = $urandom_range(0, 1) != 0;
        return x;
    endfunction

    task automatic add_item(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz, input logic [31:0] vx,
                            input logic [31:0] vy, input logic [31:0] vz,
                            input bit af, input bit bf);
        in_item_t x;
        x = {px, py, pz, vx, vy, vz, af, bf};
        pending_items.push_back(x);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        cfg_req_t w;
        w.index = idx;
        w.value = val;
        pending_writes.push_back(w);
        while (pending_writes.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_forces.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic set_all(input logic [31:0] k, input logic [31:0] c,
                           input logic [31:0] rl, input bit en);
        write_reg(CFG_SPRING, k);
        write_reg(CFG_DAMPING, c);
        write_reg(CFG_REST, rl);
        write_reg(CFG_ENABLED, {31'd0, en});
    endtask

    // Configuration writes update the predictor when accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.valid <= 1'b0;
            cfg.data <= '0;
            k_reg = 0;
            c_reg = 0;
            rest_reg = 0;
            en_reg = 1'b1;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.data.index)
                    CFG_SPRING: k_reg = longint'(signed'(cfg.data.value));
                    CFG_DAMPING: c_reg = longint'(signed'(cfg.data.value));
                    CFG_REST: rest_reg = longint'(cfg.data.value[30:0]);
                    default: en_reg = cfg.data.value[0];
                endcase
                void'(pending_writes.pop_front());
            end
            if (pending_writes.size() != 0)
            begin
                cfg.valid <= 1'b1;
                cfg.data <= pending_writes[0];
            end
            else
            begin
                cfg.valid <= 1'b0;
            end
        end
    end

    // Item driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item.valid <= 1'b0;
            item.data <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                expected_forces.push_back(spring_force(item.data));
                void'(pending_items.pop_front());
            end
            if (!item.valid || item.ready)
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
                end
                if (burst_left > 0 && pending_items.size() != 0)
                begin
                    item.valid <= 1'b1;
                    item.data <= pending_items[0];
                    burst_left--;
                end
                else
                begin
                    item.valid <= 1'b0;
                    if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                    else
                    begin
                        burst_left = 0;
                    end
                end
            end
        end
    end

    // Result monitor with a receiver that stalls on its own pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            stall_phase = 0;
            stall_len = 20;
            cycle = 0;
        end
        else
        begin
            cycle++;
            if (result.valid && result.ready)
            begin
                if (expected_forces.size() == 0)
                begin
                    $error("result with no expected force");
                    errors++;
                end
                else
                begin
                    out_item_t e;
                    e = expected_forces.pop_front();
                    if (e.force_x !== result.data.force_x)
                    begin
                        $error("force_x exp %0d got %0d", e.force_x, result.data.force_x);
                        errors++;
                    end
                    if (e.force_y !== result.data.force_y)
                    begin
                        $error("force_y exp %0d got %0d", e.force_y, result.data.force_y);
                        errors++;
                    end
                    if (e.force_z !== result.data.force_z)
                    begin
                        $error("force_z exp %0d got %0d", e.force_z, result.data.force_z);
                        errors++;
                    end
                    if (e.applied !== result.data.applied)
                    begin
                        $error("applied exp %0d got %0d", e.applied, result.data.applied);
                        errors++;
                    end
                    if (e.current_length !== result.data.current_length)
                    begin
                        $error("current_length exp %0d got %0d", e.current_length,
                               result.data.current_length);
                        errors++;
                    end
                end
            end
            stall_phase++;
            if (stall_phase >= stall_len)
            begin
                stall_phase = 0;
                stall_len = $urandom_range(4, 60);
            end
            result.ready <= (stall_len > 40) ? 1'b1 : (stall_phase % 5 < 3);
            if (cycle > LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        errors = 0;
        rst_n = 1'b0;
        item.valid = 1'b0;
        item.data = '0;
        result.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero stiffness and damping, spring on.
        add_item(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 1, 1);
        drain();
        set_all(32'h0002_0000, 32'h0000_8000, 32'h0001_0000, 1'b1);
        add_item(0, 0, 0, 0, 0, 0, 1, 1);
        add_item(0, 0, 0, 32'h0003_0000, 32'hFFFF_0000, 0, 1, 0);
        add_item(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0, 1);
        add_item(32'h0003_0000, 32'h0004_0000, 0, 32'h0001_0000, 0, 0, 0, 0);
        add_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1);
        add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1);
        add_item(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 1, 0);
        add_item(32'h0000_8000, 0, 0, 32'hFFFF_8000, 0, 0, 1, 1);
        drain();
        set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        add_item(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0, 1, 1);
        add_item(32'h8000_0000, 32'h8000_0000, 0, 32'h0001_0000, 0, 0, 1, 1);
        add_item(1, 1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 1);
        drain();
        set_all(32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b0);
        add_item(32'h0005_0000, 0, 0, 32'h0002_0000, 0, 0, 1, 1);
        add_item(32'h8000_0000, 0, 0, 32'h0002_0000, 0, 0, 1, 0);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_all($urandom_range(0, 32'h0008_0000), $urandom_range(0, 32'h0004_0000),
                           $urandom_range(0, 32'h0004_0000), 1'b1);
                1: set_all(-$urandom_range(0, 32'h0008_0000), -$urandom_range(0, 32'h4_0000),
                           $urandom_range(0, 32'h0100_0000), 1'b1);
                2: set_all($urandom, $urandom, $urandom, 1'b1);
                3: set_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
                4: set_all(32'h8000_0000, 32'h8000_0000, 0, 1'b1);
                default: set_all($urandom, $urandom, $urandom, 1'b0);
            endcase
            for (int i = 0; i < 250; i++)
            begin
                pending_items.push_back(rand_item());
            end
            drain();
        end

        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
